// ----- sv/rdu_pkg.sv -----
`default_nettype none
package rdu_pkg;

   // frame size defaults
   localparam int DEFAULT_MAX_WIDTH  = 512;
   localparam int DEFAULT_MAX_HEIGHT = 512;

   // divider shape: 16-bit numerator magnitude scaled by 2^14
   localparam int NUM_W     = 16;
   localparam int DIV_SHIFT = 14;
   localparam int DIV_STEPS = NUM_W + DIV_SHIFT;
   localparam int X_W       = DIV_STEPS + 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_X     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_Y     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FOCAL_X      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FOCAL_Y      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RADIAL_K1    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RADIAL_K2    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd7;

   // register reset values
   localparam logic [15:0] RST_CENTER = 16'd16384;
   localparam logic [15:0] RST_FOCAL  = 16'd8000;
   localparam logic [9:0]  RST_IMAGE  = 10'd512;

   localparam logic OPC_WRITE = 1'b0;
   localparam logic OPC_QUERY = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [8:0] column;
      logic [8:0] line;
      logic [7:0] pixel_in;
   } req_word_type;

   typedef struct packed {
      logic [7:0] pixel_out;
      logic       inside_res;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0]        center_x;
      logic [15:0]        center_y;
      logic [15:0]        focal_x;
      logic [15:0]        focal_y;
      logic signed [15:0] radial_k1;
      logic signed [15:0] radial_k2;
      logic [9:0]         image_width;
      logic [9:0]         image_height;
   } csr_type;

   // item travelling down the front of the pipe
   typedef struct packed {
      logic       valid;
      logic       query;
      logic [8:0] column;
      logic [8:0] line;
      logic [7:0] pixel;
   } meta_type;

   typedef struct packed {
      logic valid;
      logic query;
   } stage_tag_type;

   // source position fraction and flags
   typedef struct packed {
      logic [15:0] frac_x;
      logic [15:0] frac_y;
      logic        in_frame;
      logic        blend;
   } geom_type;

endpackage
`default_nettype wire

// ----- sv/rdu_stream_if.sv -----
`default_nettype none
interface rdu_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/rdu_divider.sv -----
`default_nettype none
// Two-lane pipelined floor divider, one quotient bit per stage.
module rdu_divider #(
   parameter type tag_type = logic
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  en,
   input  wire logic [1:0][rdu_pkg::NUM_W-1:0]        num_mag,
   input  wire logic [1:0]                            num_neg,
   input  wire logic [1:0][rdu_pkg::NUM_W-1:0]        den,
   input  tag_type                                    tag_in,
   output logic [1:0][rdu_pkg::X_W-1:0]               quot,
   output tag_type                                    tag_out
);
   localparam int STEPS = rdu_pkg::DIV_STEPS;
   localparam int NW    = rdu_pkg::NUM_W;
   localparam int SHIFT = rdu_pkg::DIV_SHIFT;
   localparam int XW    = rdu_pkg::X_W;

   logic [1:0][NW-1:0]    rem_ff [1:STEPS];
   logic [1:0][STEPS-1:0] quo_ff [1:STEPS];
   logic [1:0][NW-1:0]    num_ff [1:STEPS-1];
   logic [1:0][NW-1:0]    den_ff [1:STEPS-1];
   logic [1:0]            neg_ff [1:STEPS];
   tag_type               tag_ff [1:STEPS];

   logic [1:0][XW-1:0]    quot_ff, quot_in;
   tag_type               tag_out_ff;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int J = STEPS - 1 - k;
      logic [1:0][NW-1:0]    rem_cur, num_cur, den_cur, rem_in;
      logic [1:0][STEPS-1:0] quo_cur, quo_in;
      logic [1:0]            neg_cur, dbit;
      tag_type               tag_cur;

      if (k == 0) begin : g_first
         assign rem_cur = '0;
         assign quo_cur = '0;
         assign num_cur = num_mag;
         assign den_cur = den;
         assign neg_cur = num_neg;
         assign tag_cur = tag_in;
      end else begin : g_next
         assign rem_cur = rem_ff[k];
         assign quo_cur = quo_ff[k];
         assign num_cur = num_ff[k];
         assign den_cur = den_ff[k];
         assign neg_cur = neg_ff[k];
         assign tag_cur = tag_ff[k];
      end

      // dividend bit J; the low SHIFT bits of the scaled numerator are zero
      if (J >= SHIFT) begin : g_num_bit
         assign dbit = {num_cur[1][J-SHIFT], num_cur[0][J-SHIFT]};
      end else begin : g_zero_bit
         assign dbit = '0;
      end

      always_comb begin
         logic [NW:0] trial;
         trial = '0;
         for (int l = 0; l < 2; l++) begin
            trial = {rem_cur[l], dbit[l]};
            if (trial >= {1'b0, den_cur[l]}) begin
               rem_in[l] = NW'(trial - {1'b0, den_cur[l]});
               quo_in[l] = {quo_cur[l][STEPS-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[NW-1:0];
               quo_in[l] = {quo_cur[l][STEPS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k+1] <= '0;
         end else if (en) begin
            tag_ff[k+1] <= tag_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            quo_ff[k+1] <= quo_in;
            neg_ff[k+1] <= neg_cur;
         end
      end

      if (k + 1 < STEPS) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               num_ff[k+1] <= num_cur;
               den_ff[k+1] <= den_cur;
            end
         end
      end
   end

   // round toward minus infinity for negative numerators
   always_comb begin
      logic [XW-1:0] mag;
      mag = '0;
      for (int l = 0; l < 2; l++) begin
         mag = {2'b00, quo_ff[STEPS][l]};
         if (neg_ff[STEPS][l]) begin
            quot_in[l] = XW'(-(mag + XW'(rem_ff[STEPS][l] != '0)));
         end else begin
            quot_in[l] = mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_out_ff <= '0;
      end else if (en) begin
         tag_out_ff <= tag_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign quot    = quot_ff;
   assign tag_out = tag_out_ff;
endmodule
`default_nettype wire

// ----- sv/rdu_radial.sv -----
`default_nettype none
// Radial factor and back-projection to a source pixel, nine stages.
module rdu_radial #(
   parameter int  MAX_WIDTH  = rdu_pkg::DEFAULT_MAX_WIDTH,
   parameter int  MAX_HEIGHT = rdu_pkg::DEFAULT_MAX_HEIGHT,
   parameter type tag_type   = logic
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  rdu_pkg::csr_type                       csr,
   input  wire logic signed [rdu_pkg::X_W-1:0]    x_in,
   input  wire logic signed [rdu_pkg::X_W-1:0]    y_in,
   input  tag_type                                tag_in,
   output logic [$clog2(MAX_WIDTH)-1:0]           u_out,
   output logic [$clog2(MAX_HEIGHT)-1:0]          v_out,
   output rdu_pkg::geom_type                      geom_out,
   output tag_type                                tag_out
);
   localparam int XW  = rdu_pkg::X_W;
   localparam int UW  = $clog2(MAX_WIDTH);
   localparam int VW  = $clog2(MAX_HEIGHT);
   localparam int CWX = ($clog2(MAX_WIDTH + 1) > 10) ? $clog2(MAX_WIDTH + 1) : 10;
   localparam int CWY = ($clog2(MAX_HEIGHT + 1) > 10) ? $clog2(MAX_HEIGHT + 1) : 10;
   localparam logic signed [49:0] C_MAX = 50'sd2147483648;
   localparam logic signed [49:0] C_MIN = -50'sd2147483648;

   tag_type tag_ff [1:9];
   logic signed [XW-1:0] x_ff [1:5];
   logic signed [XW-1:0] y_ff [1:5];

   logic [61:0]        xsq_ff, ysq_ff;
   logic [30:0]        r2_ff;
   logic [61:0]        r2sq_ff;
   logic signed [47:0] k1r2_ff [3:4];
   logic signed [62:0] k2r4_ff;
   logic signed [32:0] c_ff;
   logic signed [63:0] cxp_ff, cyp_ff;
   logic signed [63:0] pxm_ff, pym_ff;
   logic signed [63:0] px_ff, py_ff;
   logic [UW-1:0]      u_ff;
   logic [VW-1:0]      v_ff;
   rdu_pkg::geom_type  geom_ff;

   // stage 1: squares
   logic [XW-2:0] x_abs, y_abs;
   logic [61:0]   xsq_in, ysq_in;
   assign x_abs  = x_in[XW-1] ? (XW-1)'(-x_in) : x_in[XW-2:0];
   assign y_abs  = y_in[XW-1] ? (XW-1)'(-y_in) : y_in[XW-2:0];
   assign xsq_in = x_abs * x_abs;
   assign ysq_in = y_abs * y_abs;

   // stage 2: r^2 in Q.16, saturated
   logic [62:0] sq_sum;
   logic [30:0] r2_in;
   assign sq_sum = {1'b0, xsq_ff} + {1'b0, ysq_ff};
   assign r2_in  = (|sq_sum[62:47]) ? 31'h7FFF_FFFF : sq_sum[46:16];

   // stage 3: r^4 product and k1 term
   logic [61:0]        r2sq_in;
   logic signed [47:0] k1r2_in;
   assign r2sq_in = r2_ff * r2_ff;
   assign k1r2_in = csr.radial_k1 * $signed({1'b0, r2_ff});

   // stage 4: k2 term
   logic [45:0]        r4;
   logic signed [62:0] k2r4_in;
   assign r4      = r2sq_ff[61:16];
   assign k2r4_in = csr.radial_k2 * $signed({1'b0, r4});

   // stage 5: factor c in Q.16, clamped to +-2^31
   logic signed [63:0] c30;
   logic signed [49:0] c_sh;
   logic signed [32:0] c_in;
   assign c30  = (64'sd1 <<< 30) + {{16{k1r2_ff[4][47]}}, k1r2_ff[4]}
               + {k2r4_ff[62], k2r4_ff};
   assign c_sh = c30[63:14];
   always_comb begin
      if (c_sh > C_MAX) begin
         c_in = C_MAX[32:0];
      end else if (c_sh < C_MIN) begin
         c_in = C_MIN[32:0];
      end else begin
         c_in = c_sh[32:0];
      end
   end

   // stage 6: c * x and c * y
   logic signed [63:0] cxp_in, cyp_in;
   assign cxp_in = c_ff * x_ff[5];
   assign cyp_in = c_ff * y_ff[5];

   // stage 7: focal scale
   logic signed [47:0] xd, yd;
   logic signed [63:0] pxm_in, pym_in;
   assign xd     = cxp_ff[63:16];
   assign yd     = cyp_ff[63:16];
   assign pxm_in = $signed({1'b0, csr.focal_x}) * xd;
   assign pym_in = $signed({1'b0, csr.focal_y}) * yd;

   // stage 8: add principal point, Q.20
   logic signed [63:0] px_in, py_in;
   assign px_in = pxm_ff + $signed({34'd0, csr.center_x, 14'd0});
   assign py_in = pym_ff + $signed({34'd0, csr.center_y, 14'd0});

   // stage 9: floor to a pixel, bounds and edge flags
   logic [CWX-1:0]    w_lim;
   logic [CWY-1:0]    h_lim;
   logic [43:0]       u_full, v_full;
   logic              in_x, in_y, bl_x, bl_y;
   rdu_pkg::geom_type geom_in;
   logic [UW-1:0]     u_in;
   logic [VW-1:0]     v_in;

   assign w_lim  = (32'(csr.image_width) < MAX_WIDTH) ? CWX'(csr.image_width)
                                                      : CWX'(MAX_WIDTH);
   assign h_lim  = (32'(csr.image_height) < MAX_HEIGHT) ? CWY'(csr.image_height)
                                                        : CWY'(MAX_HEIGHT);
   assign u_full = px_ff[63:20];
   assign v_full = py_ff[63:20];
   assign in_x   = !u_full[43] && (u_full < 44'(w_lim));
   assign in_y   = !v_full[43] && (v_full < 44'(h_lim));
   assign bl_x   = (u_full + 44'd1) < 44'(w_lim);
   assign bl_y   = (v_full + 44'd1) < 44'(h_lim);

   always_comb begin
      geom_in.frac_x   = px_ff[19:4];
      geom_in.frac_y   = py_ff[19:4];
      geom_in.in_frame = in_x && in_y;
      geom_in.blend    = bl_x && bl_y;
      // park the address at the origin when the position is off the frame
      u_in = geom_in.in_frame ? UW'(u_full) : '0;
      v_in = geom_in.in_frame ? VW'(v_full) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '{default: '0};
      end else if (en) begin
         tag_ff[1] <= tag_in;
         for (int s = 2; s <= 9; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[1] <= x_in;
         y_ff[1] <= y_in;
         for (int s = 2; s <= 5; s++) begin
            x_ff[s] <= x_ff[s-1];
            y_ff[s] <= y_ff[s-1];
         end
         xsq_ff     <= xsq_in;
         ysq_ff     <= ysq_in;
         r2_ff      <= r2_in;
         r2sq_ff    <= r2sq_in;
         k1r2_ff[3] <= k1r2_in;
         k1r2_ff[4] <= k1r2_ff[3];
         k2r4_ff    <= k2r4_in;
         c_ff       <= c_in;
         cxp_ff     <= cxp_in;
         cyp_ff     <= cyp_in;
         pxm_ff     <= pxm_in;
         pym_ff     <= pym_in;
         px_ff      <= px_in;
         py_ff      <= py_in;
         u_ff       <= u_in;
         v_ff       <= v_in;
         geom_ff    <= geom_in;
      end
   end

   assign u_out    = u_ff;
   assign v_out    = v_ff;
   assign geom_out = geom_ff;
   assign tag_out  = tag_ff[9];
endmodule
`default_nettype wire

// ----- sv/rdu_frame_store.sv -----
`default_nettype none
// Frame store split in four banks by column and row parity, so that the
// four neighbours of a pixel are read together.
module rdu_frame_store #(
   parameter int MAX_WIDTH  = rdu_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = rdu_pkg::DEFAULT_MAX_HEIGHT
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]  wr_col,
   input  wire logic [$clog2(MAX_HEIGHT)-1:0] wr_line,
   input  wire logic [7:0]                    wr_pixel,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
   input  wire logic [$clog2(MAX_HEIGHT)-1:0] rd_line,
   output logic [3:0][7:0]                    rd_pix
);
   localparam int UW     = $clog2(MAX_WIDTH);
   localparam int VW     = $clog2(MAX_HEIGHT);
   localparam int HALF_W = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
   localparam int DEPTH  = HALF_W * HALF_H;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [UW-1:0]  col_nx;
   logic [VW-1:0]  line_nx;
   logic [AW-1:0]  wr_addr;
   logic [3:0][7:0] bank_q_ff;
   logic           par_x_ff, par_y_ff;

   // next column and row, held at the last one at the frame edge
   assign col_nx  = (32'(rd_col) + 1 < MAX_WIDTH) ? UW'(32'(rd_col) + 1) : rd_col;
   assign line_nx = (32'(rd_line) + 1 < MAX_HEIGHT) ? VW'(32'(rd_line) + 1) : rd_line;
   assign wr_addr = AW'((32'(wr_line) >> 1) * HALF_W + (32'(wr_col) >> 1));

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic BX = b[0];
      localparam logic BY = b[1];
      logic [7:0]    mem [DEPTH];
      logic [UW-1:0] c_sel;
      logic [VW-1:0] l_sel;
      logic [AW-1:0] rd_addr;
      logic          we;

      assign c_sel   = (rd_col[0] == BX) ? rd_col : col_nx;
      assign l_sel   = (rd_line[0] == BY) ? rd_line : line_nx;
      assign rd_addr = AW'((32'(l_sel) >> 1) * HALF_W + (32'(c_sel) >> 1));
      assign we      = wr_en && (wr_col[0] == BX) && (wr_line[0] == BY);

      always_ff @(posedge clock) begin
         if (en) begin
            if (we) begin
               mem[wr_addr] <= wr_pixel;
            end
            bank_q_ff[b] <= mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         par_x_ff <= rd_col[0];
         par_y_ff <= rd_line[0];
      end
   end

   // put bank outputs back in neighbour order: bit 0 = right, bit 1 = below
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         rd_pix[n] = bank_q_ff[{par_y_ff ^ n[1], par_x_ff ^ n[0]}];
      end
   end
endmodule
`default_nettype wire

// ----- sv/rdu_blend.sv -----
`default_nettype none
// Bilinear blend in three stages: weights, products, sum and select.
module rdu_blend (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic [3:0][7:0]  pix,
   input  rdu_pkg::geom_type     geom_in,
   input  rdu_pkg::stage_tag_type tag_in,
   output logic [7:0]            pixel_out,
   output logic                  inside_out,
   output rdu_pkg::stage_tag_type tag_out
);
   rdu_pkg::stage_tag_type tag_ff [1:3];

   logic [3:0][33:0] wgt_ff;
   logic [3:0][7:0]  pix_ff;
   logic [1:2]       inside_ff, blend_ff;
   logic [7:0]       near_ff;
   logic [3:0][41:0] prod_ff;
   logic [7:0]       out_ff;
   logic             out_in_ff;

   logic [16:0]      wx0, wy0, wx1, wy1;
   logic [3:0][33:0] wgt_in;
   logic [3:0][41:0] prod_in;
   logic [41:0]      acc;
   logic [7:0]       out_in;

   assign wx1 = {1'b0, geom_in.frac_x};
   assign wy1 = {1'b0, geom_in.frac_y};
   assign wx0 = 17'h1_0000 - wx1;
   assign wy0 = 17'h1_0000 - wy1;

   always_comb begin
      wgt_in[0] = wx0 * wy0;
      wgt_in[1] = wx1 * wy0;
      wgt_in[2] = wx0 * wy1;
      wgt_in[3] = wx1 * wy1;
      for (int n = 0; n < 4; n++) begin
         prod_in[n] = pix_ff[n] * wgt_ff[n];
      end
   end

   assign acc = prod_ff[0] + prod_ff[1] + prod_ff[2] + prod_ff[3];

   always_comb begin
      if (!inside_ff[2]) begin
         out_in = '0;
      end else if (!blend_ff[2]) begin
         out_in = near_ff;
      end else begin
         out_in = acc[39:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '{default: '0};
      end else if (en) begin
         tag_ff[1] <= tag_in;
         tag_ff[2] <= tag_ff[1];
         tag_ff[3] <= tag_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wgt_ff       <= wgt_in;
         pix_ff       <= pix;
         inside_ff[1] <= geom_in.in_frame;
         blend_ff[1]  <= geom_in.blend;
         prod_ff      <= prod_in;
         near_ff      <= pix_ff[0];
         inside_ff[2] <= inside_ff[1];
         blend_ff[2]  <= blend_ff[1];
         out_ff       <= out_in;
         out_in_ff    <= inside_ff[2];
      end
   end

   assign pixel_out  = out_ff;
   assign inside_out = out_in_ff;
   assign tag_out    = tag_ff[3];
endmodule
`default_nettype wire

// ----- sv/radial_undistort_remap_unit.sv -----
`default_nettype none
// Channel   Dir  Word                                     Handshake
// req_ch    in   opcode, column, line, pixel_in           valid/ready
// rsp_ch    out  pixel_out, inside_res                    valid/ready
// csr_*     in   index (3 b), write data (16 b)           write enable, no stall
//
// One word enters per clock while no response word stalls at the output.
// The pipe is the input register, the 30-step floor divider (31 stages)
// that normalizes the coordinate, nine radial stages, one frame-store read
// and three blend stages. Pixel writes travel the same pipe and reach the
// store in order with the queries; they give no response word.
// Reset is synchronous and clears the configuration registers and the valid
// bits; the frame store is not cleared. The whole pipe holds while a response
// word waits at the output, so nothing is lost or repeated across a stall.
module radial_undistort_remap_unit #(
   parameter int MAX_WIDTH  = rdu_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = rdu_pkg::DEFAULT_MAX_HEIGHT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   rdu_stream_if.sink                              req_ch,
   rdu_stream_if.source                            rsp_ch,
   input  wire logic                               csr_wr_en,
   input  wire logic [rdu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rdu_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   localparam int UW = $clog2(MAX_WIDTH);
   localparam int VW = $clog2(MAX_HEIGHT);
   localparam int NW = rdu_pkg::NUM_W;
   localparam int XW = rdu_pkg::X_W;

   // configuration registers
   rdu_pkg::csr_type csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.center_x     <= rdu_pkg::RST_CENTER;
         csr_ff.center_y     <= rdu_pkg::RST_CENTER;
         csr_ff.focal_x      <= rdu_pkg::RST_FOCAL;
         csr_ff.focal_y      <= rdu_pkg::RST_FOCAL;
         csr_ff.radial_k1    <= '0;
         csr_ff.radial_k2    <= '0;
         csr_ff.image_width  <= rdu_pkg::RST_IMAGE;
         csr_ff.image_height <= rdu_pkg::RST_IMAGE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rdu_pkg::REG_CENTER_X:     csr_ff.center_x     <= csr_wdata;
            rdu_pkg::REG_CENTER_Y:     csr_ff.center_y     <= csr_wdata;
            rdu_pkg::REG_FOCAL_X:      csr_ff.focal_x      <= csr_wdata;
            rdu_pkg::REG_FOCAL_Y:      csr_ff.focal_y      <= csr_wdata;
            rdu_pkg::REG_RADIAL_K1:    csr_ff.radial_k1    <= $signed(csr_wdata);
            rdu_pkg::REG_RADIAL_K2:    csr_ff.radial_k2    <= $signed(csr_wdata);
            rdu_pkg::REG_IMAGE_WIDTH:  csr_ff.image_width  <= csr_wdata[9:0];
            rdu_pkg::REG_IMAGE_HEIGHT: csr_ff.image_height <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // advance the whole pipe unless a response word is stuck at the output
   logic                   en;
   rdu_pkg::stage_tag_type bl_tag;
   logic                   rsp_valid;

   assign rsp_valid    = bl_tag.valid && bl_tag.query;
   assign en           = !rsp_valid || rsp_ch.ready;
   assign req_ch.ready = en;

   // input register
   rdu_pkg::meta_type in_ff, in_in;

   always_comb begin
      in_in.valid  = req_ch.valid;
      in_in.query  = (req_ch.data.opcode == rdu_pkg::OPC_QUERY);
      in_in.column = req_ch.data.column;
      in_in.line   = req_ch.data.line;
      in_in.pixel  = req_ch.data.pixel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else if (en) begin
         in_ff.valid <= in_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff.query  <= in_in.query;
         in_ff.column <= in_in.column;
         in_ff.line   <= in_in.line;
         in_ff.pixel  <= in_in.pixel;
      end
   end

   // offsets from the principal point in Q.6, split into sign and magnitude
   logic signed [17:0]     dx, dy;
   logic [1:0][NW-1:0]     num_mag, den;
   logic [1:0]             num_neg;

   assign dx = $signed({3'b000, in_ff.column, 6'd0}) - $signed({2'b00, csr_ff.center_x});
   assign dy = $signed({3'b000, in_ff.line, 6'd0}) - $signed({2'b00, csr_ff.center_y});

   always_comb begin
      num_neg[0] = dx[17];
      num_neg[1] = dy[17];
      num_mag[0] = dx[17] ? NW'(-dx) : dx[NW-1:0];
      num_mag[1] = dy[17] ? NW'(-dy) : dy[NW-1:0];
      // a zero focal length counts as one sixteenth of a pixel
      den[0]     = (csr_ff.focal_x == '0) ? NW'(1) : csr_ff.focal_x;
      den[1]     = (csr_ff.focal_y == '0) ? NW'(1) : csr_ff.focal_y;
   end

   // normalized coordinates x, y in Q.16
   logic [1:0][XW-1:0] quot;
   rdu_pkg::meta_type  dv_tag;

   rdu_divider #(
      .tag_type (rdu_pkg::meta_type)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .num_mag (num_mag),
      .num_neg (num_neg),
      .den     (den),
      .tag_in  (in_ff),
      .quot    (quot),
      .tag_out (dv_tag)
   );

   // radial model and source pixel
   logic [UW-1:0]     src_u;
   logic [VW-1:0]     src_v;
   rdu_pkg::geom_type rd_geom;
   rdu_pkg::meta_type rd_tag;

   rdu_radial #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .tag_type   (rdu_pkg::meta_type)
   ) u_radial (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .csr      (csr_ff),
      .x_in     ($signed(quot[0])),
      .y_in     ($signed(quot[1])),
      .tag_in   (dv_tag),
      .u_out    (src_u),
      .v_out    (src_v),
      .geom_out (rd_geom),
      .tag_out  (rd_tag)
   );

   // frame store: writes land here in item order, queries read neighbours
   logic            wr_en;
   logic [3:0][7:0] nb_pix;

   assign wr_en = rd_tag.valid && !rd_tag.query
               && (32'(rd_tag.column) < MAX_WIDTH) && (32'(rd_tag.line) < MAX_HEIGHT);

   rdu_frame_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_frame_store (
      .clock    (clock),
      .en       (en),
      .wr_en    (wr_en),
      .wr_col   (UW'(rd_tag.column)),
      .wr_line  (VW'(rd_tag.line)),
      .wr_pixel (rd_tag.pixel),
      .rd_col   (src_u),
      .rd_line  (src_v),
      .rd_pix   (nb_pix)
   );

   // align position data with the store read
   rdu_pkg::stage_tag_type st_tag_ff;
   rdu_pkg::geom_type      st_geom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_tag_ff <= '0;
      end else if (en) begin
         st_tag_ff.valid <= rd_tag.valid;
         st_tag_ff.query <= rd_tag.query;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_geom_ff <= rd_geom;
      end
   end

   // blend; its last register is the output register
   logic [7:0] bl_pixel;
   logic       bl_inside;

   rdu_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .pix        (nb_pix),
      .geom_in    (st_geom_ff),
      .tag_in     (st_tag_ff),
      .pixel_out  (bl_pixel),
      .inside_out (bl_inside),
      .tag_out    (bl_tag)
   );

   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.data.pixel_out  = bl_pixel;
   assign rsp_ch.data.inside_res = bl_inside;
endmodule
`default_nettype wire
